// ----- hw/rtl/ep_pkg.sv -----
package ep_pkg;

   localparam int AXIS_WIDTH_DEF   = 20;
   localparam int ANGLE_WIDTH_DEF  = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // CORDIC datapath, signed, wide enough for x, y and the angle residual
   localparam int CORDIC_W = 33;
   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 33'sd652032874;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;

   // square root: 65-bit sum of squares, padded to 66 bits, one digit a stage
   localparam int SQRT_STEPS = 33;
   localparam int RAD_W      = 66;
   localparam int ROOT_W     = 33;
   localparam int SREM_W     = 36;

   // atan(2^-i) as a fraction of a 2^32 turn
   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] t;
      case (idx)
         0:  t = 32'd536870912;
         1:  t = 32'd316933406;
         2:  t = 32'd167458907;
         3:  t = 32'd85004756;
         4:  t = 32'd42667331;
         5:  t = 32'd21354465;
         6:  t = 32'd10679838;
         7:  t = 32'd5340245;
         8:  t = 32'd2670163;
         9:  t = 32'd1335087;
         10: t = 32'd667544;
         11: t = 32'd333772;
         12: t = 32'd166886;
         13: t = 32'd83443;
         14: t = 32'd41722;
         15: t = 32'd20861;
         16: t = 32'd10430;
         17: t = 32'd5215;
         18: t = 32'd2608;
         19: t = 32'd1304;
         20: t = 32'd652;
         21: t = 32'd326;
         22: t = 32'd163;
         23: t = 32'd81;
         default: t = 32'd0;
      endcase
      return t;
   endfunction

   // |v| clamped to 2^30
   function automatic logic [30:0] mag_q30(input logic signed [CORDIC_W-1:0] v);
      logic [CORDIC_W-1:0] m;
      m = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
      return (m > CORDIC_W'(ONE_Q30)) ? ONE_Q30 : m[30:0];
   endfunction

endpackage

// ----- hw/rtl/ellipse_polar_radius.sv -----
// Path from accepted item to result: CORDIC, scaling products, square root, divider, result register.
// Throughput: one item per cycle; a new item enters every cycle while the result side takes.
// The whole pipeline advances together and freezes while a result waits to be taken.
// Reset (synchronous, active high) clears every stage valid bit; data registers are not reset.
module ellipse_polar_radius #(
   parameter int AXIS_WIDTH   = ep_pkg::AXIS_WIDTH_DEF,
   parameter int ANGLE_WIDTH  = ep_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STEPS = ep_pkg::CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [AXIS_WIDTH-1:0] req_semi_major,
   input  logic [AXIS_WIDTH-1:0] req_semi_minor,
   input  logic [ANGLE_WIDTH-1:0] req_angle,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [AXIS_WIDTH-1:0] rsp_radius,
   output logic                  rsp_invalid
);
   import ep_pkg::*;

   localparam int AW  = AXIS_WIDTH;
   localparam int CW  = CORDIC_W;
   localparam int NW  = AW + 32;        // numerator a*b << guard bits
   localparam int GB  = 32 - AW;
   localparam int DRW = 34;             // divider remainder

   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------- CORDIC ----------------
   logic signed [CW-1:0] cx_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] cy_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] cz_ff [0:CORDIC_STEPS];
   logic [AW-1:0]        ca_ff [0:CORDIC_STEPS];
   logic [AW-1:0]        cb_ff [0:CORDIC_STEPS];
   logic                 codd_ff [0:CORDIC_STEPS];
   logic                 cv_ff [0:CORDIC_STEPS];

   logic [31:0] theta;
   assign theta = {req_angle, (32-ANGLE_WIDTH)'(0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (en) begin
         cv_ff[0] <= req_valid;
      end
      if (en) begin
         cx_ff[0]   <= CORDIC_START;
         cy_ff[0]   <= '0;
         cz_ff[0]   <= CW'({3'b000, theta[29:0]});
         ca_ff[0]   <= req_semi_major;
         cb_ff[0]   <= req_semi_minor;
         codd_ff[0] <= theta[30];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [CW-1:0] dx, dy, at;
      logic signed [CW-1:0] x_in, y_in, z_in;
      assign dx = cy_ff[i] >>> i;
      assign dy = cx_ff[i] >>> i;
      assign at = CW'(atan_turn(i));
      always_comb begin
         if (!cz_ff[i][CW-1]) begin
            x_in = cx_ff[i] - dx;
            y_in = cy_ff[i] + dy;
            z_in = cz_ff[i] - at;
         end else begin
            x_in = cx_ff[i] + dx;
            y_in = cy_ff[i] - dy;
            z_in = cz_ff[i] + at;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (en) begin
            cv_ff[i+1] <= cv_ff[i];
         end
         if (en) begin
            cx_ff[i+1]   <= x_in;
            cy_ff[i+1]   <= y_in;
            cz_ff[i+1]   <= z_in;
            ca_ff[i+1]   <= ca_ff[i];
            cb_ff[i+1]   <= cb_ff[i];
            codd_ff[i+1] <= codd_ff[i];
         end
      end
   end

   // ---------------- scaling products ----------------
   logic [30:0]      cmag, smag, cos_q, sin_q;
   logic [AW+30:0]   up_in, vp_in;
   logic [31:0]      u_ff, v_ff;
   logic [2*AW-1:0]  nb1_ff, nb2_ff, nb3_ff;
   logic             mv1_ff, mv2_ff, mv3_ff;
   logic [63:0]      uu_ff, vv_ff;
   logic [64:0]      sum_ff;

   assign cmag  = mag_q30(cx_ff[CORDIC_STEPS]);
   assign smag  = mag_q30(cy_ff[CORDIC_STEPS]);
   assign cos_q = codd_ff[CORDIC_STEPS] ? smag : cmag;
   assign sin_q = codd_ff[CORDIC_STEPS] ? cmag : smag;
   assign up_in = (AW+31)'(cb_ff[CORDIC_STEPS]) * (AW+31)'(cos_q);
   assign vp_in = (AW+31)'(ca_ff[CORDIC_STEPS]) * (AW+31)'(sin_q);

   always_ff @(posedge clock) begin
      if (reset) begin
         mv1_ff <= 1'b0;
         mv2_ff <= 1'b0;
         mv3_ff <= 1'b0;
      end else if (en) begin
         mv1_ff <= cv_ff[CORDIC_STEPS];
         mv2_ff <= mv1_ff;
         mv3_ff <= mv2_ff;
      end
      if (en) begin
         u_ff   <= up_in[AW+29:AW-2];
         v_ff   <= vp_in[AW+29:AW-2];
         nb1_ff <= (2*AW)'(ca_ff[CORDIC_STEPS]) * (2*AW)'(cb_ff[CORDIC_STEPS]);
         uu_ff  <= 64'(u_ff) * 64'(u_ff);
         vv_ff  <= 64'(v_ff) * 64'(v_ff);
         nb2_ff <= nb1_ff;
         sum_ff <= 65'(uu_ff) + 65'(vv_ff);
         nb3_ff <= nb2_ff;
      end
   end

   // ---------------- square root, one digit a stage ----------------
   logic [RAD_W-1:0]  srad_ff  [0:SQRT_STEPS];
   logic [ROOT_W-1:0] sroot_ff [0:SQRT_STEPS];
   logic [SREM_W-1:0] srem_ff  [0:SQRT_STEPS];
   logic [2*AW-1:0]   snb_ff   [0:SQRT_STEPS];
   logic              sv_ff    [0:SQRT_STEPS];

   always_comb begin
      srad_ff[0]  = {1'b0, sum_ff};
      sroot_ff[0] = '0;
      srem_ff[0]  = '0;
      snb_ff[0]   = nb3_ff;
      sv_ff[0]    = mv3_ff;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [SREM_W-1:0] rem2, trial;
      assign rem2  = {srem_ff[k][SREM_W-3:0], srad_ff[k][RAD_W-1:RAD_W-2]};
      assign trial = {SREM_W'(sroot_ff[k]) << 2} | SREM_W'(1);
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (en) begin
            sv_ff[k+1] <= sv_ff[k];
         end
         if (en) begin
            srad_ff[k+1] <= srad_ff[k] << 2;
            snb_ff[k+1]  <= snb_ff[k];
            if (rem2 >= trial) begin
               srem_ff[k+1]  <= rem2 - trial;
               sroot_ff[k+1] <= {sroot_ff[k][ROOT_W-2:0], 1'b1};
            end else begin
               srem_ff[k+1]  <= rem2;
               sroot_ff[k+1] <= {sroot_ff[k][ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   // ---------------- divide, one quotient bit a stage ----------------
   logic [NW-1:0]     numer;
   logic [DRW-1:0]    drem_ff [0:AW];
   logic [AW-1:0]     dlow_ff [0:AW];
   logic [AW-1:0]     dq_ff   [0:AW];
   logic [ROOT_W-1:0] dh_ff   [0:AW];
   logic              dsat_ff [0:AW];
   logic              dzero_ff[0:AW];
   logic              dv_ff   [0:AW];

   assign numer = NW'(snb_ff[SQRT_STEPS]) << GB;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= sv_ff[SQRT_STEPS];
      end
      if (en) begin
         // quotient would not fit in AW bits when the top part alone reaches h
         dsat_ff[0]  <= {1'b0, numer[NW-1:AW]} >= sroot_ff[SQRT_STEPS];
         dzero_ff[0] <= sroot_ff[SQRT_STEPS] == '0;
         drem_ff[0]  <= DRW'(numer[NW-1:AW]);
         dlow_ff[0]  <= numer[AW-1:0];
         dq_ff[0]    <= '0;
         dh_ff[0]    <= sroot_ff[SQRT_STEPS];
      end
   end

   for (genvar j = 0; j < AW; j++) begin : g_div
      logic [DRW-1:0] r2;
      assign r2 = {drem_ff[j][DRW-2:0], dlow_ff[j][AW-1]};
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_ff[j+1] <= dv_ff[j];
         end
         if (en) begin
            dlow_ff[j+1]  <= dlow_ff[j] << 1;
            dh_ff[j+1]    <= dh_ff[j];
            dsat_ff[j+1]  <= dsat_ff[j];
            dzero_ff[j+1] <= dzero_ff[j];
            if (r2 >= DRW'(dh_ff[j])) begin
               drem_ff[j+1] <= r2 - DRW'(dh_ff[j]);
               dq_ff[j+1]   <= {dq_ff[j][AW-2:0], 1'b1};
            end else begin
               drem_ff[j+1] <= r2;
               dq_ff[j+1]   <= {dq_ff[j][AW-2:0], 1'b0};
            end
         end
      end
   end

   // ---------------- result register ----------------
   logic [AW-1:0] radius_ff, radius_in;
   logic          invalid_ff;

   always_comb begin
      if (dzero_ff[AW]) begin
         radius_in = '0;
      end else if (dsat_ff[AW]) begin
         radius_in = '1;
      end else begin
         radius_in = dq_ff[AW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ff[AW];
      end
      if (en) begin
         radius_ff  <= radius_in;
         invalid_ff <= dzero_ff[AW];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_radius  = radius_ff;
   assign rsp_invalid = invalid_ff;

   // ---------------- checks ----------------
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && invalid_ff |-> radius_ff == '0)
      else $error("invalid result with nonzero radius");

   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      sv_ff[SQRT_STEPS] |-> srem_ff[SQRT_STEPS] <= (SREM_W'(sroot_ff[SQRT_STEPS]) << 1))
      else $error("square root remainder out of bound");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      dv_ff[AW] && !dzero_ff[AW] && !dsat_ff[AW] |-> drem_ff[AW] < DRW'(dh_ff[AW]))
      else $error("divider remainder not below divisor");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dv_ff[AW]) && $stable(sv_ff[SQRT_STEPS]))
      else $error("pipeline moved during stall");

endmodule

// ----- dv/ellipse_radius_checker.sv -----
module ellipse_radius_checker #(
   parameter int AXIS_WIDTH   = 20,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [AXIS_WIDTH-1:0]  req_semi_major,
   input  logic [AXIS_WIDTH-1:0]  req_semi_minor,
   input  logic [ANGLE_WIDTH-1:0] req_angle,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [AXIS_WIDTH-1:0]  rsp_radius,
   input  logic                   rsp_invalid,
   output int                     fail_count,
   output int                     pending_count
);

   typedef struct packed {
      logic [AXIS_WIDTH-1:0] radius;
      logic                  invalid;
   } radius_type;

   radius_type radius_queue[$];

   function automatic longint turn_step(input int idx);
      longint tbl [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
         21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      return tbl[idx];
   endfunction

   function automatic longint clamp_mag(input longint v);
      longint m;
      m = (v < 0) ? -v : v;
      return (m > 64'sd1073741824) ? 64'sd1073741824 : m;
   endfunction

   function automatic radius_type boundary_radius(input logic [AXIS_WIDTH-1:0] a,
         input logic [AXIS_WIDTH-1:0] b, input logic [ANGLE_WIDTH-1:0] ang);
      logic [31:0] theta;
      longint x, y, z, dx, dy, c, s, t;
      logic [63:0] u, v;
      logic [65:0] sum, rem, trial;
      logic [65:0] root;
      logic [127:0] num;
      logic [127:0] q;
      radius_type r;
      theta = 32'(ang) << (32 - ANGLE_WIDTH);
      z = longint'(theta[29:0]);
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = y >>> i;   // arithmetic shift floors
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= turn_step(i);
         end else begin
            x += dx; y -= dy; z += turn_step(i);
         end
      end
      c = clamp_mag(x);
      s = clamp_mag(y);
      if (theta[30]) begin
         t = c; c = s; s = t;
      end
      u = (64'(b) * 64'(c)) >> (AXIS_WIDTH - 2);
      v = (64'(a) * 64'(s)) >> (AXIS_WIDTH - 2);
      sum = 66'(u) * 66'(u) + 66'(v) * 66'(v);
      root = '0;
      rem = '0;
      for (int k = 32; k >= 0; k--) begin
         rem = (rem << 2) | 66'((sum >> (2 * k)) & 66'd3);
         trial = (root << 2) | 66'd1;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 66'd1;
         end else begin
            root = root << 1;
         end
      end
      if (root == 0) begin
         r.radius = '0;
         r.invalid = 1'b1;
      end else begin
         num = (128'(a) * 128'(b)) << (32 - AXIS_WIDTH);
         q = num / 128'(root);
         r.radius = (q > 128'({AXIS_WIDTH{1'b1}})) ? {AXIS_WIDTH{1'b1}} : q[AXIS_WIDTH-1:0];
         r.invalid = 1'b0;
      end
      return r;
   endfunction

   assign pending_count = radius_queue.size();

   always @(posedge clock) begin
      radius_type want;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (req_valid && req_ready)
            radius_queue.push_back(boundary_radius(req_semi_major, req_semi_minor, req_angle));
         if (rsp_valid && rsp_ready) begin
            if (radius_queue.size() == 0) begin
               $display("%0t: unexpected item radius=%0d invalid=%0b", $time,
                        rsp_radius, rsp_invalid);
               fail_count++;
            end else begin
               want = radius_queue.pop_front();
               if (want.radius !== rsp_radius) begin
                  $display("%0t: radius expected %0d actual %0d", $time,
                           want.radius, rsp_radius);
                  fail_count++;
               end
               if (want.invalid !== rsp_invalid) begin
                  $display("%0t: invalid expected %0b actual %0b", $time,
                           want.invalid, rsp_invalid);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ----- dv/tb_ellipse_polar_radius.sv -----
module tb_ellipse_polar_radius;
   import ep_pkg::*;

   localparam int AW = AXIS_WIDTH_DEF;
   localparam int GW = ANGLE_WIDTH_DEF;
   localparam int LATENCY = CORDIC_STEPS_DEF + 3 + 33 + AW + 2;
   localparam int STALL_LIMIT = 20000;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [AW-1:0] req_semi_major;
   logic [AW-1:0] req_semi_minor;
   logic [GW-1:0] req_angle;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [AW-1:0] rsp_radius;
   logic          rsp_invalid;
   int            fail_count;
   int            pending_count;
   int            idle_cycles;

   ellipse_polar_radius u_dut (.*);

   ellipse_radius_checker #(.AXIS_WIDTH(AW), .ANGLE_WIDTH(GW),
                            .CORDIC_STEPS(CORDIC_STEPS_DEF)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [AW-1:0] random_axis();
      case ($urandom_range(0, 5))
         0: return AW'($urandom_range(0, 3));
         1: return {AW{1'b1}} - AW'($urandom_range(0, 3));
         2: return AW'($urandom_range(1, 1023));
         default: return AW'($urandom);
      endcase
   endfunction

   // valid stays high into the next item when there is no gap
   task automatic send_item(input logic [AW-1:0] a, input logic [AW-1:0] b,
                            input logic [GW-1:0] ang);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_semi_major <= a;
      req_semi_minor <= b;
      req_angle      <= ang;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // result side back-pressure
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         stall = gap_length();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("ellipse_polar_radius verification failed");
         $finish;
      end
   end

   initial begin
      logic [AW-1:0] amax;
      logic [GW-1:0] quarter;
      amax = {AW{1'b1}};
      quarter = GW'(1) << (GW - 2);
      reset = 1'b1;
      req_valid = 1'b0;
      req_semi_major = '0;
      req_semi_minor = '0;
      req_angle = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, zero denominator, zero numerator, each quadrant
      send_item('0, '0, '0);
      send_item(AW'(256), '0, '0);
      send_item('0, AW'(256), quarter);
      send_item('0, AW'(256), '0);
      send_item(amax, amax, '0);
      send_item(amax, amax, {GW{1'b1}});
      send_item(amax, AW'(1), quarter);
      send_item(AW'(1), amax, '0);
      send_item(AW'(1), AW'(1), GW'(quarter / 2));
      send_item(AW'(512), AW'(256), quarter);
      send_item(AW'(512), AW'(256), GW'(2 * quarter));
      send_item(AW'(512), AW'(256), GW'(3 * quarter));
      send_item(AW'(512), AW'(256), GW'(quarter / 3));
      send_item(amax, '0, quarter);
      send_item(AW'('h55555), AW'('hAAAAA), GW'('h5555));
      send_item(AW'('hAAAAA), AW'('h55555), GW'('hAAAA));
      send_item(AW'(3), AW'(2), GW'(3 * quarter + 7));

      // drain before continuing
      req_valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);

      for (int n = 0; n < 800; n++) begin
         send_item(random_axis(), random_axis(), GW'($urandom));
         if (n == 400) begin
            req_valid <= 1'b0;
            wait (pending_count == 0);
            @(negedge clock);
         end
      end
      req_valid <= 1'b0;

      wait (pending_count == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_count == 0)
         $display("ellipse_polar_radius verification clean");
      else
         $display("ellipse_polar_radius verification failed");
      $finish;
   end

endmodule
